### hw/rtl/afl_pkg.sv
`default_nettype none

package afl_pkg;

  // Lexer states
  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_NUM     = 4'd1,
    ST_IDENT   = 4'd2,
    ST_SLASH   = 4'd3,
    ST_BSLASH  = 4'd4,
    ST_LT      = 4'd5,
    ST_GT      = 4'd6,
    ST_EQ      = 4'd7,
    ST_EQEQ    = 4'd8,
    ST_COMMENT = 4'd9,
    ST_UNDER   = 4'd10
  } afl_state_e;

  // Token kinds
  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_TILDE  = 5'd1;
  localparam logic [4:0] K_PLUS   = 5'd2;
  localparam logic [4:0] K_MINUS  = 5'd3;
  localparam logic [4:0] K_STAR   = 5'd4;
  localparam logic [4:0] K_CARET  = 5'd5;
  localparam logic [4:0] K_LPAR   = 5'd6;
  localparam logic [4:0] K_RPAR   = 5'd7;
  localparam logic [4:0] K_LBRK   = 5'd8;
  localparam logic [4:0] K_RBRK   = 5'd9;
  localparam logic [4:0] K_COMMA  = 5'd10;
  localparam logic [4:0] K_DOLLAR = 5'd11;
  localparam logic [4:0] K_PCT    = 5'd12;
  localparam logic [4:0] K_ROOT   = 5'd13;
  localparam logic [4:0] K_ERR    = 5'd14;
  localparam logic [4:0] K_NUM    = 5'd15;
  localparam logic [4:0] K_VAR    = 5'd16;
  localparam logic [4:0] K_AND    = 5'd17;
  localparam logic [4:0] K_OR     = 5'd18;
  localparam logic [4:0] K_RELOP  = 5'd19;
  localparam logic [4:0] K_DIV    = 5'd20;
  localparam logic [4:0] K_IMPL   = 5'd21;
  localparam logic [4:0] K_TRUE   = 5'd22;
  localparam logic [4:0] K_FALSE  = 5'd23;
  localparam logic [4:0] K_QF     = 5'd24;

  // Subkinds
  localparam logic [2:0] SUB_NONE = 3'd0;
  localparam logic [2:0] SUB_LT   = 3'd0;
  localparam logic [2:0] SUB_LE   = 3'd1;
  localparam logic [2:0] SUB_GT   = 3'd2;
  localparam logic [2:0] SUB_GE   = 3'd3;
  localparam logic [2:0] SUB_EQ   = 3'd4;
  localparam logic [2:0] SUB_NE   = 3'd5;
  localparam logic [2:0] SUB_EX   = 3'd0;
  localparam logic [2:0] SUB_ALL  = 3'd1;

  // Keyword slots: true, false, ex, all
  localparam int unsigned KW_NUM = 4;
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd5, 3'd2, 3'd3};
  localparam logic [2:0] ROOT_LEN = 3'd6;
  localparam logic [2:0] PROG_MAX = 3'd7;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam int unsigned OUT_POS_W  = 16;
  localparam int unsigned OUT_DATA_W = 72;

  typedef struct packed {
    logic                 last;
    logic [OUT_POS_W-1:0] end_column;
    logic [OUT_POS_W-1:0] end_line;
    logic [OUT_POS_W-1:0] start_column;
    logic [OUT_POS_W-1:0] start_line;
    logic [2:0]           token_subkind;
    logic [4:0]           token_kind;
  } afl_token_t;

endpackage

`default_nettype wire

### hw/rtl/algebraic_formula_lexer_unit.sv
// Formula lexer: one character (or end-of-input mark) per request in, tokens out.
// Input channel s_axis: tdata[7:0] is the character, tuser is the end-of-input
// flag. Output channel m_axis: one token per request, tdata carries kind,
// subkind and start/end line and column, tlast marks the final token that
// one input request caused. An input gives zero, one or two tokens.
// A token is written into the token queue when its input is taken and is read
// out from the queue head. Throughput: one character per cycle while s_axis_tready
// is high; the lexer step is a single pass of combinational logic from the state
// registers into a four-entry token queue. A two-token input needs two transfers.
// s_axis_tready is high while the queue has room for two tokens, so the
// input keeps flowing while a finished token waits on the output.
// When the receiver stalls, tokens stay in the queue and the input stops once
// fewer than two slots are free; nothing is dropped.
// Reset (rst_ni low) empties the queue, returns to the start state and sets
// line and column to 1. Positions saturate at 2**POSITION_BITS-1 and are
// reported in their low 16 bits.
`default_nettype none

module algebraic_formula_lexer_unit #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] token_kind, [7:5] token_subkind, [23:8] start_line,
  // [39:24] start_column, [55:40] end_line, [71:56] end_column
  output logic [afl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned PW = POSITION_BITS;
  localparam logic [PW-1:0] POS_ONE = PW'(1);
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  afl_pkg::afl_state_e state_q, state_d;
  logic [PW-1:0] tsl_q, tsl_d, tsc_q, tsc_d;
  logic [PW-1:0] next_line_q, next_col_q, prev_line_q, prev_col_q;
  logic [2:0]    prog_q, prog_d;
  logic [3:0]    kw_q, kw_d;

  afl_pkg::afl_token_t fifo_q [afl_pkg::FIFO_DEPTH];
  logic [afl_pkg::PTR_W-1:0] wr_q, rd_q;
  logic [afl_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic in_fire, out_fire;
  logic [7:0] ch;
  logic eof;
  logic [PW-1:0] ln, cl;
  logic redo, run_start;
  logic t0_v, t1_v;
  afl_pkg::afl_token_t t0, t1, first_tok;
  logic push_first, push_second;
  logic [1:0] n_push;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case ({k, p})
      {2'd0, 3'd0}: r = "t";
      {2'd0, 3'd1}: r = "r";
      {2'd0, 3'd2}: r = "u";
      {2'd0, 3'd3}: r = "e";
      {2'd1, 3'd0}: r = "f";
      {2'd1, 3'd1}: r = "a";
      {2'd1, 3'd2}: r = "l";
      {2'd1, 3'd3}: r = "s";
      {2'd1, 3'd4}: r = "e";
      {2'd2, 3'd0}: r = "e";
      {2'd2, 3'd1}: r = "x";
      {2'd3, 3'd0}: r = "a";
      {2'd3, 3'd1}: r = "l";
      {2'd3, 3'd2}: r = "l";
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] root_char(input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (p)
      3'd0:    r = "_";
      3'd1:    r = "r";
      3'd2:    r = "o";
      3'd3:    r = "o";
      3'd4:    r = "t";
      3'd5:    r = "_";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Drop keyword candidates that do not match the character at position p
  function automatic logic [3:0] kw_keep(input logic [3:0] cand, input logic [2:0] p,
                                         input logic [7:0] c);
    logic [3:0] r;
    for (int k = 0; k < afl_pkg::KW_NUM; k++) begin
      r[k] = cand[k] && (p < afl_pkg::KW_LEN[k]) && (kw_char(2'(k), p) == c);
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic afl_pkg::afl_token_t mk_tok(
    input logic [4:0] kind, input logic [2:0] sub,
    input logic [PW-1:0] sl, input logic [PW-1:0] sc,
    input logic [PW-1:0] el, input logic [PW-1:0] ec);
    afl_pkg::afl_token_t t;
    t.token_kind    = kind;
    t.token_subkind = sub;
    t.start_line    = afl_pkg::OUT_POS_W'(sl);
    t.start_column  = afl_pkg::OUT_POS_W'(sc);
    t.end_line      = afl_pkg::OUT_POS_W'(el);
    t.end_column    = afl_pkg::OUT_POS_W'(ec);
    t.last          = 1'b0;
    return t;
  endfunction

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign ch  = s_axis_tdata;
  assign eof = s_axis_tuser;
  assign ln  = next_line_q;
  assign cl  = next_col_q;

  // Next state and tokens for one character: continuation pass, then start pass
  always_comb begin
    state_d   = state_q;
    tsl_d     = tsl_q;
    tsc_d     = tsc_q;
    prog_d    = prog_q;
    kw_d      = kw_q;
    redo      = 1'b0;
    run_start = 1'b0;
    t0_v      = 1'b0;
    t1_v      = 1'b0;
    t0        = '0;
    t1        = '0;

    if (in_fire) begin
      state_d = afl_pkg::ST_START;
      unique case (state_q)
        afl_pkg::ST_START: run_start = 1'b1;
        afl_pkg::ST_NUM: begin
          if (!eof && is_digit(ch)) begin
            state_d = afl_pkg::ST_NUM;
          end else begin
            t0_v = 1'b1;
            t0   = mk_tok(afl_pkg::K_NUM, afl_pkg::SUB_NONE, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            redo = 1'b1;
          end
        end
        afl_pkg::ST_IDENT: begin
          if (!eof && (is_digit(ch) || is_alpha(ch) || ch == "_")) begin
            kw_d    = kw_keep(kw_q, prog_q, ch);
            prog_d  = (prog_q < afl_pkg::PROG_MAX) ? prog_q + 3'd1 : afl_pkg::PROG_MAX;
            state_d = afl_pkg::ST_IDENT;
          end else begin
            t0_v = 1'b1;
            t0   = mk_tok(afl_pkg::K_VAR, afl_pkg::SUB_NONE, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            // classify a finished identifier against the surviving keywords
            for (int k = 0; k < afl_pkg::KW_NUM; k++) begin
              if (kw_q[k] && afl_pkg::KW_LEN[k] == prog_q) begin
                case (k)
                  0: t0.token_kind = afl_pkg::K_TRUE;
                  1: t0.token_kind = afl_pkg::K_FALSE;
                  2: begin
                    t0.token_kind    = afl_pkg::K_QF;
                    t0.token_subkind = afl_pkg::SUB_EX;
                  end
                  default: begin
                    t0.token_kind    = afl_pkg::K_QF;
                    t0.token_subkind = afl_pkg::SUB_ALL;
                  end
                endcase
              end
            end
            redo = 1'b1;
          end
        end
        afl_pkg::ST_SLASH: begin
          t0_v = 1'b1;
          if (!eof && ch == "\\") begin
            t0 = mk_tok(afl_pkg::K_AND, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
          end else if (!eof && ch == "=") begin
            t0 = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_NE, tsl_q, tsc_q, ln, cl);
          end else begin
            t0   = mk_tok(afl_pkg::K_DIV, afl_pkg::SUB_NONE, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            redo = 1'b1;
          end
        end
        afl_pkg::ST_BSLASH: begin
          t0_v = 1'b1;
          if (!eof && ch == "/") begin
            t0 = mk_tok(afl_pkg::K_OR, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
          end else begin
            t0   = mk_tok(afl_pkg::K_ERR, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
            redo = eof;
          end
        end
        afl_pkg::ST_LT: begin
          t0_v = 1'b1;
          if (!eof && ch == "=") begin
            t0 = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_LE, tsl_q, tsc_q, ln, cl);
          end else if (!eof && ch == ">") begin
            t0 = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_NE, tsl_q, tsc_q, ln, cl);
          end else begin
            t0   = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_LT, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            redo = 1'b1;
          end
        end
        afl_pkg::ST_GT: begin
          t0_v = 1'b1;
          if (!eof && ch == "=") begin
            t0 = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_GE, tsl_q, tsc_q, ln, cl);
          end else begin
            t0   = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_GT, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            redo = 1'b1;
          end
        end
        afl_pkg::ST_EQ: begin
          if (!eof && ch == "=") begin
            state_d = afl_pkg::ST_EQEQ;
          end else begin
            t0_v = 1'b1;
            t0   = mk_tok(afl_pkg::K_RELOP, afl_pkg::SUB_EQ, tsl_q, tsc_q,
                          prev_line_q, prev_col_q);
            redo = 1'b1;
          end
        end
        afl_pkg::ST_EQEQ: begin
          t0_v = 1'b1;
          if (!eof && ch == ">") begin
            t0 = mk_tok(afl_pkg::K_IMPL, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
          end else begin
            t0   = mk_tok(afl_pkg::K_ERR, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
            redo = eof;
          end
        end
        afl_pkg::ST_COMMENT: begin
          if (eof || ch == 8'h0A) begin
            redo = 1'b1;
          end else begin
            state_d = afl_pkg::ST_COMMENT;
          end
        end
        afl_pkg::ST_UNDER: begin
          if (!eof && prog_q < afl_pkg::ROOT_LEN && root_char(prog_q) == ch) begin
            prog_d = prog_q + 3'd1;
            if (prog_q + 3'd1 >= afl_pkg::ROOT_LEN) begin
              t0_v = 1'b1;
              t0   = mk_tok(afl_pkg::K_ROOT, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
            end else begin
              state_d = afl_pkg::ST_UNDER;
            end
          end else begin
            t0_v = 1'b1;
            t0   = mk_tok(afl_pkg::K_ERR, afl_pkg::SUB_NONE, tsl_q, tsc_q, ln, cl);
            redo = eof;
          end
        end
        default: run_start = 1'b1;
      endcase

      // Start a new token with this character
      if (run_start || redo) begin
        tsl_d = ln;
        tsc_d = cl;
        if (eof) begin
          t1_v = 1'b1;
          t1   = mk_tok(afl_pkg::K_END, afl_pkg::SUB_NONE, ln, cl, ln, cl);
        end else if (is_digit(ch)) begin
          state_d = afl_pkg::ST_NUM;
        end else if (is_alpha(ch)) begin
          kw_d    = kw_keep(4'hF, 3'd0, ch);
          prog_d  = 3'd1;
          state_d = afl_pkg::ST_IDENT;
        end else begin
          case (ch) inside
            "/":  state_d = afl_pkg::ST_SLASH;
            "\\": state_d = afl_pkg::ST_BSLASH;
            "<":  state_d = afl_pkg::ST_LT;
            ">":  state_d = afl_pkg::ST_GT;
            "=":  state_d = afl_pkg::ST_EQ;
            " ", [8'h09:8'h0D]: ;
            "#":  state_d = afl_pkg::ST_COMMENT;
            "_": begin
              prog_d  = 3'd1;
              state_d = afl_pkg::ST_UNDER;
            end
            default: begin
              t1_v = 1'b1;
              t1   = mk_tok(afl_pkg::K_ERR, afl_pkg::SUB_NONE, ln, cl, ln, cl);
              case (ch)
                "~":     t1.token_kind = afl_pkg::K_TILDE;
                "+":     t1.token_kind = afl_pkg::K_PLUS;
                "-":     t1.token_kind = afl_pkg::K_MINUS;
                "*":     t1.token_kind = afl_pkg::K_STAR;
                "^":     t1.token_kind = afl_pkg::K_CARET;
                "(":     t1.token_kind = afl_pkg::K_LPAR;
                ")":     t1.token_kind = afl_pkg::K_RPAR;
                "[":     t1.token_kind = afl_pkg::K_LBRK;
                "]":     t1.token_kind = afl_pkg::K_RBRK;
                ",":     t1.token_kind = afl_pkg::K_COMMA;
                "$":     t1.token_kind = afl_pkg::K_DOLLAR;
                "%":     t1.token_kind = afl_pkg::K_PCT;
                default: t1.token_kind = afl_pkg::K_ERR;
              endcase
            end
          endcase
        end
      end
    end

    t0.last = !t1_v;
    t1.last = 1'b1;
  end

  // Queue write control
  always_comb begin
    first_tok   = t0_v ? t0 : t1;
    push_first  = in_fire && (t0_v || t1_v);
    push_second = in_fire && t0_v && t1_v;
    n_push      = {1'b0, push_first} + {1'b0, push_second};
    cnt_d       = cnt_q + afl_pkg::CNT_W'(n_push) - afl_pkg::CNT_W'(out_fire);
  end

  assign s_axis_tready = (cnt_q <= afl_pkg::CNT_W'(afl_pkg::FIFO_DEPTH - 2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {fifo_q[rd_q].end_column, fifo_q[rd_q].end_line,
                          fifo_q[rd_q].start_column, fifo_q[rd_q].start_line,
                          fifo_q[rd_q].token_subkind, fifo_q[rd_q].token_kind};
  assign m_axis_tlast  = fifo_q[rd_q].last;

  // Lexer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afl_pkg::ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  // Positions and keyword tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsl_q       <= POS_ONE;
      tsc_q       <= POS_ONE;
      next_line_q <= POS_ONE;
      next_col_q  <= POS_ONE;
      prev_line_q <= POS_ONE;
      prev_col_q  <= POS_ONE;
      prog_q      <= 3'd0;
      kw_q        <= 4'hF;
    end else if (in_fire) begin
      tsl_q       <= tsl_d;
      tsc_q       <= tsc_d;
      prog_q      <= prog_d;
      kw_q        <= kw_d;
      prev_line_q <= ln;
      prev_col_q  <= cl;
      if (!eof && ch == 8'h0A) begin
        next_line_q <= sat_inc(ln);
        next_col_q  <= POS_ONE;
      end else begin
        next_col_q  <= sat_inc(cl);
      end
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + afl_pkg::PTR_W'(n_push);
      cnt_q <= cnt_d;
      if (out_fire) begin
        rd_q <= rd_q + afl_pkg::PTR_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_first) begin
      fifo_q[wr_q] <= first_tok;
    end
    if (push_second) begin
      fifo_q[wr_q + afl_pkg::PTR_W'(1)] <= t1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/afl_checker.sv
`default_nettype none

module afl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [afl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [4:0] kind;
  logic [2:0] sub;
  logic       in_eof;

  assign kind   = m_axis_tdata[4:0];
  assign sub    = m_axis_tdata[7:5];
  assign in_eof = s_axis_tvalid && s_axis_tready && s_axis_tuser && (s_axis_tdata == s_axis_tdata);

  // End of input always leaves a token valid on the output in the next cycle
  a_eof_gives_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_eof |=> m_axis_tvalid)
    else $error("no token after end-of-input request");

  // End token is always the final token of its request
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == afl_pkg::K_END |-> m_axis_tlast)
    else $error("end token without tlast");

  // Only relational and quantifier tokens carry a subkind
  a_sub_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind != afl_pkg::K_RELOP && kind != afl_pkg::K_QF
      |-> sub == afl_pkg::SUB_NONE)
    else $error("subkind set on plain token");

  // Stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output token changed under stall");

endmodule

bind algebraic_formula_lexer_unit afl_checker u_afl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### bench/tb_algebraic_formula_lexer_unit.sv
`timescale 1ns / 100ps

module tb_algebraic_formula_lexer_unit;
  import afl_pkg::*;

  localparam int unsigned DIR_N     = 26;
  localparam int unsigned PHASE_N   = 350;
  localparam int unsigned HOLD_LEN  = 400;
  localparam logic [15:0] POS_TOP   = 16'hFFFF;

  // Idle profiles: percent of cycles each side stays away from the bus
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    bit          typed;
    logic [4:0]  kind;
    logic [2:0]  sub;
    logic [15:0] sl;
    logic [15:0] sc;
    logic [15:0] el;
    logic [15:0] ec;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] character
  logic        s_axis_tuser  = 1'b0;   // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [4:0] token_kind, [7:5] token_subkind, [23:8] start_line,
  // [39:24] start_column, [55:40] end_line, [71:56] end_column
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Lexer mirror
  afl_state_e  lx_state;
  logic [15:0] tok_line, tok_col;
  logic [15:0] nxt_line, nxt_col;
  logic [15:0] prv_line, prv_col;
  logic [2:0]  kw_prog;
  logic [3:0]  kw_cand;
  afl_token_t  pending_tokens [$];

  logic [8:0]  char_q [$];  // {end_of_input, character}
  dir_row_t    dir_tab [DIR_N];
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  string kw_text [4] = '{"true", "false", "ex", "all"};
  string root_text   = "_root_";
  string single_ops  = "~+-*^()[],$%";
  string kw_like [11] = '{"true", "false", "ex", "all", "tru", "falsey", "exa", "al",
                          "True", "e", "a1"};
  string multi_ops [13] = '{"/\\", "\\/", "==>", "<", "<=", ">", ">=", "=", "/=", "<>",
                            "/", "\\", "=="};

  always #6 clk_i = ~clk_i;

  algebraic_formula_lexer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void push_tok(logic [4:0] kind, logic [2:0] sub,
                                   logic [15:0] sl, logic [15:0] sc,
                                   logic [15:0] el, logic [15:0] ec);
    afl_token_t t;
    t.last          = 1'b0;
    t.token_kind    = kind;
    t.token_subkind = sub;
    t.start_line    = sl;
    t.start_column  = sc;
    t.end_line      = el;
    t.end_column    = ec;
    pending_tokens.push_back(t);
  endfunction

  // Drop keyword candidates that no longer match and advance the match count
  function automatic void ident_char(logic [7:0] c);
    for (int k = 0; k < 4; k++) begin
      if (kw_cand[k] && (kw_prog >= kw_text[k].len() || kw_text[k][kw_prog] != c))
        kw_cand[k] = 1'b0;
    end
    if (kw_prog < PROG_MAX) kw_prog = kw_prog + 3'd1;
  endfunction

  function automatic void ident_finish();
    logic [4:0] kind;
    logic [2:0] sub;
    kind = K_VAR;
    sub  = SUB_NONE;
    for (int k = 0; k < 4; k++) begin
      if (kw_cand[k] && kw_text[k].len() == kw_prog) begin
        case (k)
          0:       kind = K_TRUE;
          1:       kind = K_FALSE;
          2: begin
            kind = K_QF;
            sub  = SUB_EX;
          end
          default: begin
            kind = K_QF;
            sub  = SUB_ALL;
          end
        endcase
      end
    end
    push_tok(kind, sub, tok_line, tok_col, prv_line, prv_col);
  endfunction

  // One pass over the character; returns 1 when it must be looked at again
  function automatic bit lex_pass(logic [7:0] c, bit eoi, logic [15:0] ln, logic [15:0] cl);
    afl_state_e s;
    s = lx_state;
    lx_state = ST_START;
    case (s)
      ST_NUM: begin
        if (!eoi && is_digit(c)) begin
          lx_state = ST_NUM;
          return 1'b0;
        end
        push_tok(K_NUM, SUB_NONE, tok_line, tok_col, prv_line, prv_col);
        return 1'b1;
      end
      ST_IDENT: begin
        if (!eoi && (is_digit(c) || is_alpha(c) || c == "_")) begin
          ident_char(c);
          lx_state = ST_IDENT;
          return 1'b0;
        end
        ident_finish();
        return 1'b1;
      end
      ST_SLASH: begin
        if (!eoi && c == "\\") begin
          push_tok(K_AND, SUB_NONE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        if (!eoi && c == "=") begin
          push_tok(K_RELOP, SUB_NE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        push_tok(K_DIV, SUB_NONE, tok_line, tok_col, prv_line, prv_col);
        return 1'b1;
      end
      ST_BSLASH: begin
        if (!eoi && c == "/") begin
          push_tok(K_OR, SUB_NONE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        push_tok(K_ERR, SUB_NONE, tok_line, tok_col, ln, cl);
        return eoi;
      end
      ST_LT: begin
        if (!eoi && c == "=") begin
          push_tok(K_RELOP, SUB_LE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        if (!eoi && c == ">") begin
          push_tok(K_RELOP, SUB_NE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        push_tok(K_RELOP, SUB_LT, tok_line, tok_col, prv_line, prv_col);
        return 1'b1;
      end
      ST_GT: begin
        if (!eoi && c == "=") begin
          push_tok(K_RELOP, SUB_GE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        push_tok(K_RELOP, SUB_GT, tok_line, tok_col, prv_line, prv_col);
        return 1'b1;
      end
      ST_EQ: begin
        if (!eoi && c == "=") begin
          lx_state = ST_EQEQ;
          return 1'b0;
        end
        push_tok(K_RELOP, SUB_EQ, tok_line, tok_col, prv_line, prv_col);
        return 1'b1;
      end
      ST_EQEQ: begin
        if (!eoi && c == ">") begin
          push_tok(K_IMPL, SUB_NONE, tok_line, tok_col, ln, cl);
          return 1'b0;
        end
        push_tok(K_ERR, SUB_NONE, tok_line, tok_col, ln, cl);
        return eoi;
      end
      ST_COMMENT: begin
        if (eoi || c == "\n") return 1'b1;
        lx_state = ST_COMMENT;
        return 1'b0;
      end
      ST_UNDER: begin
        if (!eoi && kw_prog < ROOT_LEN && root_text[kw_prog] == c) begin
          kw_prog = kw_prog + 3'd1;
          if (kw_prog >= ROOT_LEN) push_tok(K_ROOT, SUB_NONE, tok_line, tok_col, ln, cl);
          else lx_state = ST_UNDER;
          return 1'b0;
        end
        push_tok(K_ERR, SUB_NONE, tok_line, tok_col, ln, cl);
        return eoi;
      end
      default: ;
    endcase

    // Start state: open a new token here
    tok_line = ln;
    tok_col  = cl;
    if (eoi) begin
      push_tok(K_END, SUB_NONE, ln, cl, ln, cl);
      return 1'b0;
    end
    if (is_digit(c)) begin
      lx_state = ST_NUM;
      return 1'b0;
    end
    if (is_alpha(c)) begin
      kw_cand = 4'hF;
      kw_prog = 3'd0;
      ident_char(c);
      lx_state = ST_IDENT;
      return 1'b0;
    end
    case (c)
      "/":  lx_state = ST_SLASH;
      "\\": lx_state = ST_BSLASH;
      "<":  lx_state = ST_LT;
      ">":  lx_state = ST_GT;
      "=":  lx_state = ST_EQ;
      "#":  lx_state = ST_COMMENT;
      "_": begin
        kw_prog  = 3'd1;
        lx_state = ST_UNDER;
      end
      default: begin
        if (!is_space(c)) begin
          for (int k = 0; k < single_ops.len(); k++) begin
            if (single_ops[k] == c) begin
              push_tok(5'(k + 1), SUB_NONE, ln, cl, ln, cl);
              return 1'b0;
            end
          end
          push_tok(K_ERR, SUB_NONE, ln, cl, ln, cl);
        end
      end
    endcase
    return 1'b0;
  endfunction

  // Expected tokens for one accepted request, plus position tracking
  function automatic void lex_step(logic [7:0] c, bit eoi);
    logic [15:0] ln, cl;
    int          n0;
    ln = nxt_line;
    cl = nxt_col;
    n0 = pending_tokens.size();
    if (lex_pass(c, eoi, ln, cl)) void'(lex_pass(c, eoi, ln, cl));
    prv_line = ln;
    prv_col  = cl;
    if (!eoi && c == "\n") begin
      nxt_line = (ln != POS_TOP) ? ln + 16'd1 : ln;
      nxt_col  = 16'd1;
    end else begin
      nxt_col = (cl != POS_TOP) ? cl + 16'd1 : cl;
    end
    if (pending_tokens.size() > n0) pending_tokens[pending_tokens.size()-1].last = 1'b1;
  endfunction

  function automatic void add_char(logic [7:0] c);
    char_q.push_back({1'b0, c});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(5))
      0:       return " ";
      1:       return "\t";
      2:       return "\n";
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  // Queue one piece of formula text, mostly well formed, some noise
  function automatic void gen_fragment();
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(4, 1);
      repeat (n) add_char(8'("0" + $urandom_range(9)));
    end else if (pick < 26) begin
      add_char($urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25)));
      n = $urandom_range(5);
      repeat (n) add_char(word_char());
    end else if (pick < 36) begin
      add_text(kw_like[$urandom_range(10)]);
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0, 1:    add_text("_root_");
        2:       add_text("_roo");
        default: add_text("__");
      endcase
    end else if (pick < 55) begin
      add_char(single_ops[$urandom_range(single_ops.len() - 1)]);
    end else if (pick < 70) begin
      add_text(multi_ops[$urandom_range(12)]);
    end else if (pick < 76) begin
      add_char("#");
      n = $urandom_range(6);
      repeat (n) add_char(8'($urandom_range(126, 32)));
      if ($urandom_range(4) != 0) add_char("\n");
    end else if (pick < 83) begin
      add_char(8'($urandom_range(255)));
    end else if (pick < 87) begin
      char_q.push_back({1'b1, 8'($urandom_range(255))});
    end else begin
      add_char(ws_char());
    end
    if ($urandom_range(9) < 5) add_char(ws_char());
  endfunction

  function automatic void set_idle(idle_mode_e m);
    case (m)
      IDLE_NONE: begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      IDLE_SENDER: begin
        src_idle_pct = 71;
        snk_idle_pct = 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct = 0;
        snk_idle_pct = 71;
      end
      default: begin
        src_idle_pct = 8;
        snk_idle_pct = 8;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_char(logic [7:0] c, logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic feed(logic [8:0] e);
    send_char(e[7:0], e[8]);
    lex_step(e[7:0], e[8]);
  endtask

  task automatic run_phase(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (char_q.size() == 0) gen_fragment();
      feed(char_q.pop_front());
    end
  endtask

  // Receiver: check each token against the oldest expectation, then drive tready (hold-off or random idle)
  always @(posedge clk_i) begin : rx_check
    afl_token_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token, expected none actual %h", $time, got);
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
        check_field("token_subkind", 16'(want.token_subkind), 16'(got.token_subkind));
        check_field("start_line", want.start_line, got.start_line);
        check_field("start_column", want.start_column, got.start_column);
        check_field("end_line", want.end_line, got.end_line);
        check_field("end_column", want.end_column, got.end_column);
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #(64'd800_000 * 12);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n0;
    lx_state = ST_START;
    tok_line = 16'd1;
    tok_col  = 16'd1;
    nxt_line = 16'd1;
    nxt_col  = 16'd1;
    prv_line = 16'd1;
    prv_col  = 16'd1;
    kw_prog  = 3'd0;
    kw_cand  = 4'hF;

    // ch, eoi, typed, kind, sub, start line/col, end line/col
    dir_tab = '{
      '{8'hFF, 1'b1, 1'b1, K_END, SUB_NONE, 16'd1, 16'd1, 16'd1, 16'd1},
      '{8'h00, 1'b0, 1'b1, K_ERR, SUB_NONE, 16'd1, 16'd2, 16'd1, 16'd2},
      '{8'hFF, 1'b0, 1'b1, K_ERR, SUB_NONE, 16'd1, 16'd3, 16'd1, 16'd3},
      '{8'h80, 1'b0, 1'b1, K_ERR, SUB_NONE, 16'd1, 16'd4, 16'd1, 16'd4},
      '{"\\",  1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"x",   1'b0, 1'b1, K_ERR, SUB_NONE, 16'd1, 16'd5, 16'd1, 16'd6},
      '{"=",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"=",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{8'h41, 1'b1, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"_",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"r",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{8'h00, 1'b1, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"#",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"a",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"\n",  1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"1",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"2",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"+",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"a",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"l",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"l",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{" ",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"<",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{">",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"#",   1'b0, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
      '{"\n",  1'b1, 1'b0, K_END, SUB_NONE, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed rows replace the mirror's tokens with fixed ones
    set_idle(IDLE_NONE);
    for (int r = 0; r < DIR_N; r++) begin
      send_char(dir_tab[r].ch, dir_tab[r].eoi);
      n0 = pending_tokens.size();
      lex_step(dir_tab[r].ch, dir_tab[r].eoi);
      if (dir_tab[r].typed) begin
        while (pending_tokens.size() > n0) void'(pending_tokens.pop_back());
        push_tok(dir_tab[r].kind, dir_tab[r].sub, dir_tab[r].sl, dir_tab[r].sc,
                 dir_tab[r].el, dir_tab[r].ec);
        pending_tokens[pending_tokens.size()-1].last = 1'b1;
      end
    end

    // Random text; the first phase opens with a long receiver hold-off
    hold_req++;
    run_phase(PHASE_N);
    set_idle(IDLE_SENDER);
    run_phase(PHASE_N);
    set_idle(IDLE_RECEIVER);
    run_phase(PHASE_N);
    set_idle(IDLE_BOTH);
    run_phase(PHASE_N);
    while (char_q.size() != 0) feed(char_q.pop_front());

    // End marks in the middle of text, then a short random tail
    set_idle(IDLE_NONE);
    add_text("ab 12<=x");
    char_q.push_back({1'b1, 8'h00});
    add_char("\n");
    add_text("x_1/\\true ");
    char_q.push_back({1'b1, 8'h0A});
    add_char("\n");
    add_char("%");
    while (char_q.size() != 0) feed(char_q.pop_front());
    set_idle(IDLE_BOTH);
    run_phase(40);
    while (char_q.size() != 0) feed(char_q.pop_front());
    s_axis_tvalid <= 1'b0;

    // Drain and let the block settle
    for (int w = 0; w < 5000 && pending_tokens.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      mismatches += pending_tokens.size();
      $display("%0t: missing tokens, expected %0d more actual none", $time,
               pending_tokens.size());
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
